FILE: hw/rtl/cd_toc_query_unit_macros.svh
// Assertion helpers used by cd_toc_query_unit.
`ifndef CD_TOC_QUERY_UNIT_MACROS_SVH
`define CD_TOC_QUERY_UNIT_MACROS_SVH

// Same-cycle implication.
`define CTQ_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication.
`define CTQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

FILE: hw/rtl/ctq_pkg.sv
package ctq_pkg;

   localparam int MAX_TRACKS = 99;
   localparam int IDX_W      = $clog2(MAX_TRACKS);
   localparam int COUNT_W    = 7;

   localparam logic [7:0] TRACK_NUM_MAX   = 8'd99;
   localparam logic [7:0] FIRST_TRACK_BCD = 8'h01;

   localparam logic signed [33:0] END_LIMIT = 34'sd2147483647;

   // frame to minute/second conversion
   localparam int LEADIN_FRAMES = 150;
   localparam int MAX_FRAMES    = 100 * 60 * 75;
   localparam int FRAME_W       = 19;
   localparam int SECS_W        = 13;
   localparam int MINS_W        = 7;
   localparam int RSEC_W        = 6;
   // floor(n/75) = (n * 447393) >> 25 for n < 450000
   localparam logic [FRAME_W-1:0] FRAME_RECIP = 19'd447393;
   localparam int                 FRAME_SHIFT = 25;
   // floor(n/60) = (n * 17477) >> 20 for n < 6000
   localparam logic [14:0]        SEC_RECIP   = 15'd17477;
   localparam int                 SEC_SHIFT   = 20;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_OTHER = 2'd1,
      OP_GETTN = 2'd2,
      OP_GETTD = 2'd3
   } op_type;

   typedef struct packed {
      logic [7:0]          number;
      logic signed [31:0]  start_lba;
      logic signed [33:0]  end_lba;
      logic                shape_ok;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic                table_ok;
      logic                found;
      logic signed [31:0]  found_lba;
      logic signed [33:0]  last_end;
   } scan_status_type;

   typedef struct packed {
      logic        done;
      logic [7:0]  min_bcd;
      logic [7:0]  sec_bcd;
   } time_result_type;

   // binary 0..99 to two BCD digits; tens = (v * 103) >> 10
   function automatic logic [7:0] bin_to_bcd(input logic [6:0] v);
      logic [13:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      prod = 14'(v) * 14'd103;
      tens = prod[13:10];
      ones = 7'(v - 7'({3'b000, tens} * 7'd10));
      return {tens, ones[3:0]};
   endfunction

endpackage

FILE: hw/rtl/ctq_ram.sv
module ctq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/ctq_scan.sv
// Walks table entries as they come out of the RAM, one per cycle.
module ctq_scan (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  logic                        in_vld,
   input  ctq_pkg::entry_type          entry,
   input  logic [6:0]                  tn,
   output ctq_pkg::scan_status_type    status
);

   logic                table_ok_ff, table_ok_in;
   logic                found_ff, found_in;
   logic signed [31:0]  found_lba_ff, found_lba_in;
   logic signed [33:0]  last_end_ff, last_end_in;
   logic [7:0]          prev_num_ff, prev_num_in;
   logic signed [33:0]  prev_end_ff, prev_end_in;
   logic signed [33:0]  start_ext;
   logic                bad;

   always_comb begin
      start_ext = {{2{entry.start_lba[31]}}, entry.start_lba};
      bad = (entry.number > ctq_pkg::TRACK_NUM_MAX) ||
            (entry.number != 8'(prev_num_ff + 8'd1)) ||
            entry.start_lba[31] || !entry.shape_ok ||
            (start_ext < prev_end_ff) ||
            (entry.end_lba > ctq_pkg::END_LIMIT);

      table_ok_in  = table_ok_ff;
      found_in     = found_ff;
      found_lba_in = found_lba_ff;
      last_end_in  = last_end_ff;
      prev_num_in  = prev_num_ff;
      prev_end_in  = prev_end_ff;

      if (clear) begin
         table_ok_in = 1'b1;
         found_in    = 1'b0;
         prev_num_in = 8'd0;
         prev_end_in = -34'sd1;
      end else if (in_vld) begin
         if (bad) begin
            table_ok_in = 1'b0;
         end
         // first match wins
         if (!found_ff && (entry.number == {1'b0, tn})) begin
            found_in     = 1'b1;
            found_lba_in = entry.start_lba;
         end
         last_end_in = entry.end_lba;
         prev_num_in = entry.number;
         prev_end_in = entry.end_lba;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_ok_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         table_ok_ff <= table_ok_in;
         found_ff    <= found_in;
      end
      found_lba_ff <= found_lba_in;
      last_end_ff  <= last_end_in;
      prev_num_ff  <= prev_num_in;
      prev_end_ff  <= prev_end_in;
   end

   assign status = '{table_ok:  table_ok_ff,
                     found:     found_ff,
                     found_lba: found_lba_ff,
                     last_end:  last_end_ff};

endmodule

FILE: hw/rtl/ctq_time.sv
// Frame count to BCD minutes/seconds, five register stages.
module ctq_time (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           go,
   input  logic [ctq_pkg::FRAME_W-1:0]    frames,
   output ctq_pkg::time_result_type       result
);

   localparam int P1_W = 2 * ctq_pkg::FRAME_W;
   localparam int P2_W = ctq_pkg::SECS_W + 15;

   logic [4:0]                     vld_ff, vld_in;
   logic [ctq_pkg::FRAME_W-1:0]    frames_ff;
   logic [P1_W-1:0]                prod1_ff, prod1_in;
   logic [ctq_pkg::SECS_W-1:0]     secs;
   logic [ctq_pkg::SECS_W-1:0]     secs_ff;
   logic [P2_W-1:0]                prod2_ff, prod2_in;
   logic [ctq_pkg::MINS_W-1:0]     mins;
   logic [ctq_pkg::MINS_W-1:0]     mins_ff;
   logic [ctq_pkg::RSEC_W-1:0]     rsec_in, rsec_ff;
   logic [7:0]                     min_bcd_ff, sec_bcd_ff;

   always_comb begin
      vld_in   = {vld_ff[3:0], go};
      prod1_in = P1_W'(frames_ff) * P1_W'(ctq_pkg::FRAME_RECIP);
      secs     = prod1_ff[ctq_pkg::FRAME_SHIFT +: ctq_pkg::SECS_W];
      prod2_in = P2_W'(secs) * P2_W'(ctq_pkg::SEC_RECIP);
      mins     = prod2_ff[ctq_pkg::SEC_SHIFT +: ctq_pkg::MINS_W];
      rsec_in  = ctq_pkg::RSEC_W'(secs_ff -
                 ctq_pkg::SECS_W'(ctq_pkg::SECS_W'(mins) * ctq_pkg::SECS_W'(60)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      frames_ff  <= frames;
      prod1_ff   <= prod1_in;
      secs_ff    <= secs;
      prod2_ff   <= prod2_in;
      mins_ff    <= mins;
      rsec_ff    <= rsec_in;
      min_bcd_ff <= ctq_pkg::bin_to_bcd(mins_ff);
      sec_bcd_ff <= ctq_pkg::bin_to_bcd(7'(rsec_ff));
   end

   assign result = '{done: vld_ff[4], min_bcd: min_bcd_ff, sec_bcd: sec_bcd_ff};

endmodule

FILE: hw/rtl/cd_toc_query_unit.sv
// Channel  | Ports                                  | Word
// ---------+----------------------------------------+-------------------------------
// request  | req_valid / req_ready                  | op, entry fields, param, status
// response | rsp_valid / rsp_ready                  | ok, status, first, second BCD
// csr      | csr_wr_en / csr_wr_data                | entry count, no stall
//
// Load: accept, end-address add + RAM write, response stage. Other: accept, response stage.
// Refusals caught at accept (bad count, bad parameter) go straight to the response stage.
// GetTN walks the table, then drains and checks; GetTD adds the five-stage time conversion
// unless refused after the walk. The table walk reads one valid entry per cycle up to the count.
// Synchronous reset sets the entry count to 0; the table RAM is not cleared.
// A finished word waits in the response register while the next request is taken;
// the unit stalls only when a second word is ready before the first is taken.
module cd_toc_query_unit (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_op,
   input  logic [6:0]          req_entry_index,
   input  logic [7:0]          req_entry_number,
   input  logic signed [31:0]  req_entry_lba,
   input  logic [31:0]         req_entry_sectors,
   input  logic signed [31:0]  req_entry_postgap,
   input  logic                req_param_present,
   input  logic [7:0]          req_param_byte,
   input  logic [7:0]          req_drive_status,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_ok,
   output logic [7:0]          rsp_status_byte,
   output logic [7:0]          rsp_first_bcd,
   output logic [7:0]          rsp_second_bcd,

   input  logic                csr_wr_en,
   input  logic [6:0]          csr_wr_data
);

`include "cd_toc_query_unit_macros.svh"

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_LOAD   = 7'b0000010,
      S_SCAN   = 7'b0000100,
      S_DRAIN  = 7'b0001000,
      S_CHECK  = 7'b0010000,
      S_TIME   = 7'b0100000,
      S_RESULT = 7'b1000000
   } state_type;

   localparam int IDX_W   = ctq_pkg::IDX_W;
   localparam int COUNT_W = ctq_pkg::COUNT_W;

   state_type                  state_ff, state_in;
   logic [COUNT_W-1:0]         count_ff, count_in;

   // response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_ok_ff, rsp_ok_in;
   logic [7:0]                 rsp_status_ff, rsp_status_in;
   logic [7:0]                 rsp_first_ff, rsp_first_in;
   logic [7:0]                 rsp_second_ff, rsp_second_in;

   // pending result
   logic                       res_ok_ff, res_ok_in;
   logic [7:0]                 res_status_ff, res_status_in;
   logic [7:0]                 res_first_ff, res_first_in;
   logic [7:0]                 res_second_ff, res_second_in;

   // query context
   ctq_pkg::op_type            op_ff, op_in;
   logic [6:0]                 tn_ff, tn_in;
   logic [7:0]                 status_ff, status_in;

   // table walk
   logic [IDX_W-1:0]           rd_addr_ff, rd_addr_in;
   logic                       rd_vld_ff;

   // load context
   logic                       ld_en_ff, ld_en_in;
   logic [IDX_W-1:0]           ld_idx_ff, ld_idx_in;
   logic [7:0]                 ld_num_ff, ld_num_in;
   logic signed [31:0]         ld_start_ff, ld_start_in;
   logic signed [33:0]         ld_sum_ff, ld_sum_in;
   logic signed [31:0]         ld_gap_ff, ld_gap_in;
   logic                       ld_shape_ff, ld_shape_in;

   logic                       req_acc;
   logic                       count_bad;
   logic                       param_ok;
   logic [3:0]                 bcd_hi, bcd_lo;
   logic [COUNT_W-1:0]         count_m1;
   logic [IDX_W-1:0]           last_idx;
   logic [33:0]                lba_sel;
   logic [33:0]                frames_full;
   logic                       lba_bad;
   logic                       time_go;

   ctq_pkg::entry_type         wr_entry;
   logic [ctq_pkg::ENTRY_W-1:0] rd_word;
   ctq_pkg::entry_type         rd_entry;
   logic                       ram_wr_en;
   ctq_pkg::scan_status_type   scan_st;
   ctq_pkg::time_result_type   tm_res;

   assign req_ready = (state_ff == S_IDLE);
   assign req_acc   = req_valid && req_ready;

   assign count_bad = (count_ff == '0) || (count_ff > COUNT_W'(ctq_pkg::MAX_TRACKS));
   assign bcd_hi    = req_param_byte[7:4];
   assign bcd_lo    = req_param_byte[3:0];
   assign param_ok  = req_param_present && (bcd_hi <= 4'd9) && (bcd_lo <= 4'd9);
   assign count_m1  = COUNT_W'(count_ff - 7'd1);
   assign last_idx  = count_m1[IDX_W-1:0];

   // GetTD address: lead-out, matched start, or not found (-1)
   always_comb begin
      if (tn_ff == 7'd0) begin
         lba_sel = scan_st.last_end;
      end else if (scan_st.found) begin
         lba_sel = {{2{scan_st.found_lba[31]}}, scan_st.found_lba};
      end else begin
         lba_sel = '1;
      end
      lba_bad     = lba_sel[33] ||
                    (lba_sel >= 34'(ctq_pkg::MAX_FRAMES - ctq_pkg::LEADIN_FRAMES));
      frames_full = 34'(lba_sel + 34'(ctq_pkg::LEADIN_FRAMES));
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_ok_in     = rsp_ok_ff;
      rsp_status_in = rsp_status_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      res_ok_in     = res_ok_ff;
      res_status_in = res_status_ff;
      res_first_in  = res_first_ff;
      res_second_in = res_second_ff;
      op_in         = op_ff;
      tn_in         = tn_ff;
      status_in     = status_ff;
      rd_addr_in    = rd_addr_ff;
      ld_en_in      = ld_en_ff;
      ld_idx_in     = ld_idx_ff;
      ld_num_in     = ld_num_ff;
      ld_start_in   = ld_start_ff;
      ld_sum_in     = ld_sum_ff;
      ld_gap_in     = ld_gap_ff;
      ld_shape_in   = ld_shape_ff;
      time_go       = 1'b0;

      if (csr_wr_en) begin
         count_in = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               res_ok_in     = 1'b1;
               res_status_in = 8'd0;
               res_first_in  = 8'd0;
               res_second_in = 8'd0;
               op_in         = ctq_pkg::op_type'(req_op);
               status_in     = req_drive_status;
               tn_in         = 7'({3'b000, bcd_hi} * 7'd10) + 7'(bcd_lo);
               rd_addr_in    = '0;
               case (ctq_pkg::op_type'(req_op))
                  ctq_pkg::OP_LOAD: begin
                     ld_en_in    = req_entry_index < COUNT_W'(ctq_pkg::MAX_TRACKS);
                     ld_idx_in   = req_entry_index[IDX_W-1:0];
                     ld_num_in   = req_entry_number;
                     ld_start_in = req_entry_lba;
                     // start + sectors now, + postgap next cycle
                     ld_sum_in   = {{2{req_entry_lba[31]}}, req_entry_lba} +
                                   $signed({2'b00, req_entry_sectors});
                     ld_gap_in   = req_entry_postgap;
                     ld_shape_in = (req_entry_sectors != 32'd0) && !req_entry_postgap[31];
                     state_in    = S_LOAD;
                  end
                  ctq_pkg::OP_OTHER: begin
                     state_in = S_RESULT;
                  end
                  ctq_pkg::OP_GETTN, ctq_pkg::OP_GETTD: begin
                     if (count_bad ||
                         ((ctq_pkg::op_type'(req_op) == ctq_pkg::OP_GETTD) && !param_ok)) begin
                        res_ok_in = 1'b0;
                        state_in  = S_RESULT;
                     end else begin
                        state_in  = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_RESULT;
                  end
               endcase
            end
         end
         S_LOAD: begin
            state_in = S_RESULT;
         end
         S_SCAN: begin
            if (rd_addr_ff == last_idx) begin
               state_in = S_DRAIN;
            end else begin
               rd_addr_in = IDX_W'(rd_addr_ff + 1'b1);
            end
         end
         S_DRAIN: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!scan_st.table_ok) begin
               res_ok_in = 1'b0;
               state_in  = S_RESULT;
            end else if (op_ff == ctq_pkg::OP_GETTN) begin
               // a valid table runs 1..count
               res_status_in = status_ff;
               res_first_in  = ctq_pkg::FIRST_TRACK_BCD;
               res_second_in = ctq_pkg::bin_to_bcd(count_ff);
               state_in      = S_RESULT;
            end else if (lba_bad) begin
               res_ok_in = 1'b0;
               state_in  = S_RESULT;
            end else begin
               time_go  = 1'b1;
               state_in = S_TIME;
            end
         end
         S_TIME: begin
            if (tm_res.done) begin
               res_status_in = status_ff;
               res_first_in  = tm_res.min_bcd;
               res_second_in = tm_res.sec_bcd;
               state_in      = S_RESULT;
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_ok_in     = res_ok_ff;
               rsp_status_in = res_status_ff;
               rsp_first_in  = res_first_ff;
               rsp_second_in = res_second_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         ld_en_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= (state_ff == S_SCAN);
         ld_en_ff     <= ld_en_in;
      end
      rsp_ok_ff     <= rsp_ok_in;
      rsp_status_ff <= rsp_status_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      res_ok_ff     <= res_ok_in;
      res_status_ff <= res_status_in;
      res_first_ff  <= res_first_in;
      res_second_ff <= res_second_in;
      op_ff         <= op_in;
      tn_ff         <= tn_in;
      status_ff     <= status_in;
      rd_addr_ff    <= rd_addr_in;
      ld_idx_ff     <= ld_idx_in;
      ld_num_ff     <= ld_num_in;
      ld_start_ff   <= ld_start_in;
      ld_sum_ff     <= ld_sum_in;
      ld_gap_ff     <= ld_gap_in;
      ld_shape_ff   <= ld_shape_in;
   end

   assign ram_wr_en = (state_ff == S_LOAD) && ld_en_ff;
   assign wr_entry  = '{number:    ld_num_ff,
                        start_lba: ld_start_ff,
                        end_lba:   ld_sum_ff + {{2{ld_gap_ff[31]}}, ld_gap_ff},
                        shape_ok:  ld_shape_ff};
   assign rd_entry  = ctq_pkg::entry_type'(rd_word);

   ctq_ram #(
      .WIDTH (ctq_pkg::ENTRY_W),
      .DEPTH (ctq_pkg::MAX_TRACKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ld_idx_ff),
      .wr_data (wr_entry),
      .rd_en   (state_ff == S_SCAN),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_word)
   );

   ctq_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .clear  (req_acc),
      .in_vld (rd_vld_ff),
      .entry  (rd_entry),
      .tn     (tn_ff),
      .status (scan_st)
   );

   ctq_time u_time (
      .clock  (clock),
      .reset  (reset),
      .go     (time_go),
      .frames (frames_full[ctq_pkg::FRAME_W-1:0]),
      .result (tm_res)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_status_byte = rsp_status_ff;
   assign rsp_first_bcd   = rsp_first_ff;
   assign rsp_second_bcd  = rsp_second_ff;

   `CTQ_ASSERT_IMPL(a_time_done_in_time, clock, reset, tm_res.done, state_ff == S_TIME)
   `CTQ_ASSERT_IMPL(a_scan_addr_in_range, clock, reset, state_ff == S_SCAN,
                    COUNT_W'(rd_addr_ff) < count_ff)
   `CTQ_ASSERT_IMPL(a_refusal_zero, clock, reset, rsp_valid && !rsp_ok,
                    (rsp_status_byte == 8'd0) && (rsp_first_bcd == 8'd0) &&
                    (rsp_second_bcd == 8'd0))
   `CTQ_ASSERT_NEXT(a_empty_table_refused, clock, reset,
                    req_acc && (count_ff == '0) &&
                    ((req_op == ctq_pkg::OP_GETTN) || (req_op == ctq_pkg::OP_GETTD)),
                    (state_ff == S_RESULT) && !res_ok_ff)

endmodule

FILE: tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ctq_pkg::*;

   // cycles with no handshake at all before the run is declared hung
   localparam int STALL_LIMIT = 3000;
   // words (not counting loads to ignored slots) before the quiet tail starts
   localparam int RANDOM_STOP = 480;
   // each slot of a well-formed table owns this many sectors, so mixed partial rebuilds
   // from one base never make tracks overlap and, from base 0, every time fits 100 min
   localparam longint SLOT_SPAN = 4500;
   localparam longint END_MAX = 64'sd2147483647;
   localparam int FRAMES_PER_SEC = 75;
   localparam int SECS_PER_MIN = 60;

   typedef struct {
      op_type             op;
      logic [6:0]         index;
      logic [7:0]         number;
      logic signed [31:0] lba;
      logic [31:0]        sectors;
      logic signed [31:0] postgap;
      logic               present;
      logic [7:0]         param;
      logic [7:0]         status;
   } toc_request_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] status;
      logic [7:0] first;
      logic [7:0] second;
   } toc_answer_type;

   // ways to break one entry of an otherwise good table
   typedef enum int {
      SPOIL_NUMBER,
      SPOIL_NEG_START,
      SPOIL_ZERO_LEN,
      SPOIL_NEG_GAP,
      SPOIL_OVERLAP,
      SPOIL_END_WRAP
   } spoil_kind_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_op;
   logic [6:0]         req_entry_index;
   logic [7:0]         req_entry_number;
   logic signed [31:0] req_entry_lba;
   logic [31:0]        req_entry_sectors;
   logic signed [31:0] req_entry_postgap;
   logic               req_param_present;
   logic [7:0]         req_param_byte;
   logic [7:0]         req_drive_status;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_ok;
   logic [7:0]         rsp_status_byte;
   logic [7:0]         rsp_first_bcd;
   logic [7:0]         rsp_second_bcd;
   logic               csr_wr_en;
   logic [6:0]         csr_wr_data;

   cd_toc_query_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_entry_index   (req_entry_index),
      .req_entry_number  (req_entry_number),
      .req_entry_lba     (req_entry_lba),
      .req_entry_sectors (req_entry_sectors),
      .req_entry_postgap (req_entry_postgap),
      .req_param_present (req_param_present),
      .req_param_byte    (req_param_byte),
      .req_drive_status  (req_drive_status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ok            (rsp_ok),
      .rsp_status_byte   (rsp_status_byte),
      .rsp_first_bcd     (rsp_first_bcd),
      .rsp_second_bcd    (rsp_second_bcd),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   // ---------------------------------------------------------------------
   // Shadow of the track table and the entry count, updated as words are taken
   // ---------------------------------------------------------------------
   bit [7:0] toc_number   [MAX_TRACKS];
   longint   toc_start    [MAX_TRACKS];
   longint   toc_end      [MAX_TRACKS];
   bit       toc_shape_ok [MAX_TRACKS];
   int       toc_count;

   toc_answer_type answers_due[$];

   int  errors;
   int  words_sent;
   int  ignored_loads;
   int  answers_seen;
   int  refusals;
   int  csr_writes;
   int  idle_pct;
   bit  no_idling;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] to_bcd(input int v);
      logic [3:0] tens;
      logic [3:0] ones;
      tens = 4'((v / 10) % 10);
      ones = 4'(v % 10);
      return {tens, ones};
   endfunction

   // count in range, numbers 1,2,3.., sane shapes, no overlap, ends in 31 bits
   function automatic bit toc_table_valid();
      longint prev_end;
      int     prev_num;
      bit     good;
      prev_end = -1;
      prev_num = 0;
      good = (toc_count != 0) && (toc_count <= MAX_TRACKS);
      for (int i = 0; good && i < toc_count; i++) begin
         if (toc_number[i] == 0 || toc_number[i] > int'(TRACK_NUM_MAX) ||
             int'(toc_number[i]) != prev_num + 1 || toc_start[i] < 0 ||
             !toc_shape_ok[i] || toc_start[i] < prev_end || toc_end[i] > END_MAX) begin
            good = 1'b0;
         end else begin
            prev_num = toc_number[i];
            prev_end = toc_end[i];
         end
      end
      return good;
   endfunction

   // expected answer for one accepted word; loads update the shadow table
   function automatic toc_answer_type answer_for(input toc_request_type r);
      toc_answer_type a;
      longint      sec;
      longint      gap;
      longint      lba;
      longint      frames;
      int          tn;
      int          secs;
      bit          found;
      a = '0;
      a.ok = 1'b1;
      case (r.op)
         OP_LOAD: begin
            if (r.index < MAX_TRACKS) begin
               sec = r.sectors;
               gap = r.postgap;
               toc_number[r.index] = r.number;
               toc_start[r.index] = r.lba;
               toc_end[r.index] = toc_start[r.index] + sec + gap;
               toc_shape_ok[r.index] = (sec != 0) && (gap >= 0);
            end
         end
         OP_OTHER: begin
            a.ok = 1'b1;
         end
         OP_GETTN: begin
            if (!toc_table_valid()) begin
               a.ok = 1'b0;
            end else begin
               a.status = r.status;
               a.first = to_bcd(toc_number[0]);
               a.second = to_bcd(toc_number[toc_count - 1]);
            end
         end
         default: begin
            tn = r.param[7:4] * 10 + r.param[3:0];
            if (!toc_table_valid() || !r.present || r.param[7:4] > 9 ||
                r.param[3:0] > 9) begin
               a.ok = 1'b0;
            end else begin
               lba = -1;
               found = 1'b0;
               if (tn == 0) begin
                  lba = toc_end[toc_count - 1];   // lead-out
               end else begin
                  for (int i = 0; i < toc_count; i++) begin
                     if (!found && toc_number[i] == tn) begin
                        found = 1'b1;
                        lba = toc_start[i];
                     end
                  end
               end
               frames = lba + LEADIN_FRAMES;
               if (lba < 0 || frames >= MAX_FRAMES) begin
                  a.ok = 1'b0;
               end else begin
                  secs = int'(frames / FRAMES_PER_SEC);
                  a.status = r.status;
                  a.first = to_bcd(secs / SECS_PER_MIN);
                  a.second = to_bcd(secs % SECS_PER_MIN);
               end
            end
         end
      endcase
      return a;
   endfunction

   // every field random, so unused bits still toggle
   function automatic toc_request_type random_word();
      toc_request_type r;
      r.op = op_type'($urandom_range(0, 3));
      r.index = 7'($urandom);
      r.number = 8'($urandom);
      r.lba = $urandom;
      r.sectors = $urandom;
      r.postgap = $urandom;
      r.present = 1'($urandom);
      r.param = 8'($urandom);
      r.status = 8'($urandom);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request side: inputs change on the falling edge, valid holds until taken
   // ---------------------------------------------------------------------
   task automatic send_word(input toc_request_type r);
      int gap;
      @(negedge clock);
      if (!no_idling && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 14);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_op = r.op;
      req_entry_index = r.index;
      req_entry_number = r.number;
      req_entry_lba = r.lba;
      req_entry_sectors = r.sectors;
      req_entry_postgap = r.postgap;
      req_param_present = r.present;
      req_param_byte = r.param;
      req_drive_status = r.status;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      answers_due.push_back(answer_for(r));
      words_sent++;
      if (r.op == OP_LOAD && r.index >= MAX_TRACKS)
         ignored_loads++;
   endtask

   // drop valid and hold off until every answer is back
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (answers_due.size() != 0) @(negedge clock);
   endtask

   // only written with the unit idle
   task automatic set_track_count(input int n);
      drain();
      csr_wr_en = 1'b1;
      csr_wr_data = 7'(n);
      @(negedge clock);
      csr_wr_en = 1'b0;
      toc_count = n & 127;
      csr_writes++;
   endtask

   task automatic load_track(input int slot, input int num, input longint lba,
                             input longint sectors, input longint gap);
      toc_request_type r;
      r = random_word();
      r.op = OP_LOAD;
      r.index = 7'(slot);
      r.number = 8'(num);
      r.lba = 32'(lba);
      r.sectors = 32'(sectors);
      r.postgap = 32'(gap);
      send_word(r);
   endtask

   task automatic ask(input op_type op, input bit present, input logic [7:0] param);
      toc_request_type r;
      r = random_word();
      r.op = op;
      r.present = present;
      r.param = param;
      send_word(r);
   endtask

   // well-formed track in its own slot span
   task automatic place_track(input int slot, input longint base);
      longint lba;
      lba = base + longint'(slot) * SLOT_SPAN;
      if ($urandom_range(0, 9) == 0)
         load_track(slot, slot + 1, lba, 1, 0);
      else
         load_track(slot, slot + 1, lba + $urandom_range(0, 200),
                    $urandom_range(1, 3000), $urandom_range(0, 1300));
   endtask

   task automatic build_table(input int n, input longint base);
      for (int s = 0; s < n; s++)
         place_track(s, base);
   endtask

   task automatic spoil_track(input int slot);
      spoil_kind_type kind;
      int          num;
      longint      lba;
      longint      sec;
      longint      gap;
      num = slot + 1;
      lba = toc_start[slot];
      sec = 1;
      gap = 0;
      kind = spoil_kind_type'($urandom_range(0, 5));
      case (kind)
         SPOIL_NUMBER: begin
            case ($urandom_range(0, 2))
               0: num = 0;
               1: num = slot + 2;
               default: num = $urandom_range(100, 255);
            endcase
         end
         SPOIL_NEG_START: begin
            lba = ($urandom_range(0, 1) == 0) ? -1 : -longint'($urandom_range(2, 1 << 30));
         end
         SPOIL_ZERO_LEN: begin
            sec = 0;
            gap = $urandom_range(0, 100);
         end
         SPOIL_NEG_GAP: begin
            sec = $urandom_range(1, 3000);
            gap = ($urandom_range(0, 1) == 0) ? -1 : -longint'(32'h8000_0000);
         end
         SPOIL_OVERLAP: begin
            lba = (slot == 0) ? -1 : toc_end[slot - 1] - $urandom_range(1, 100);
         end
         default: begin
            // end past 31 bits; the corner case drives all three to their max
            if ($urandom_range(0, 3) == 0) begin
               lba = END_MAX;
               sec = 64'hFFFF_FFFF;
               gap = END_MAX;
            end else begin
               lba = END_MAX - $urandom_range(0, 1000);
               sec = $urandom_range(2000, 1 << 30);
               gap = $urandom_range(0, 100);
            end
         end
      endcase
      load_track(slot, num, lba, sec, gap);
   endtask

   // mixed queries plus stray loads
   task automatic query_burst(input int n);
      int pick;
      int lim;
      int tn;
      toc_request_type r;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         r = random_word();
         if (pick < 40) begin
            lim = (toc_count >= 1 && toc_count <= MAX_TRACKS) ? toc_count : 99;
            tn = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, lim);
            r.op = OP_GETTD;
            r.present = 1'b1;
            r.param = to_bcd(tn);
         end else if (pick < 50) begin
            r.op = OP_GETTD;             // raw parameter: bad BCD, missing byte
         end else if (pick < 75) begin
            r.op = OP_GETTN;
         end else if (pick < 85) begin
            r.op = OP_OTHER;
         end else if (pick < 95) begin
            r.op = OP_LOAD;
            r.index = 7'($urandom_range(MAX_TRACKS, 127));
         end else begin
            r.op = OP_LOAD;              // junk load, may break the table
         end
         send_word(r);
         if ($urandom_range(0, 19) == 0)
            drain();
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // count is 0 after reset: every GetTN/GetTD refused, loads past the table ignored
   task automatic test_empty_table();
      toc_request_type r;
      ask(OP_GETTN, 1'b1, 8'h00);
      ask(OP_GETTD, 1'b1, 8'h01);
      ask(OP_GETTD, 1'b1, 8'h00);
      ask(OP_OTHER, 1'b0, 8'hFF);
      load_track(MAX_TRACKS, 1, 0, 1, 0);
      r = random_word();
      r.op = OP_LOAD;
      r.index = 7'h7F;
      r.number = 8'hFF;
      r.lba = 32'h8000_0000;
      r.sectors = 32'hFFFF_FFFF;
      r.postgap = 32'h7FFF_FFFF;
      send_word(r);
   endtask

   // three tracks, second starts exactly on the first one's end
   task automatic test_small_table();
      load_track(0, 1, 0, 1000, 0);
      load_track(1, 2, 1000, 2000, 150);
      load_track(2, 3, 3150, 5000, 0);
      set_track_count(3);
      ask(OP_GETTN, 1'b1, 8'h00);
      ask(OP_GETTD, 1'b1, 8'h00);      // lead-out
      ask(OP_GETTD, 1'b1, 8'h01);
      ask(OP_GETTD, 1'b1, 8'h02);
      ask(OP_GETTD, 1'b1, 8'h03);
      ask(OP_GETTD, 1'b1, 8'h04);      // not in the table
      ask(OP_GETTD, 1'b1, 8'h1A);      // low digit not BCD
      ask(OP_GETTD, 1'b1, 8'hA1);      // high digit not BCD
      ask(OP_GETTD, 1'b0, 8'h01);      // parameter missing
   endtask

   // last track one frame short of 100 min, lead-out just past it
   task automatic test_time_limit();
      load_track(2, 3, MAX_FRAMES - LEADIN_FRAMES - 1, 1, 0);
      ask(OP_GETTD, 1'b1, 8'h03);
      ask(OP_GETTD, 1'b1, 8'h00);
   endtask

   // out-of-sequence number, then a one-track table
   task automatic test_broken_table();
      load_track(1, 5, 1000, 2000, 150);
      ask(OP_GETTN, 1'b1, 8'h00);
      set_track_count(1);
      ask(OP_GETTN, 1'b1, 8'h00);
      ask(OP_GETTD, 1'b1, 8'h01);
   endtask

   // all 99 slots loaded; from here on no query can touch a blank entry
   task automatic test_full_table();
      build_table(MAX_TRACKS, 0);
      set_track_count(MAX_TRACKS);
      ask(OP_GETTN, 1'b1, 8'h00);
      ask(OP_GETTD, 1'b1, 8'h99);
      ask(OP_GETTD, 1'b1, 8'h00);
      query_burst(25);
   endtask

   // phases: new entry count, maybe a rebuilt or broken table, then queries
   task automatic test_random_settings();
      int     n;
      int     phase;
      bit     rebuild;
      longint base;
      phase = 0;
      while (words_sent - ignored_loads < RANDOM_STOP) begin
         case ($urandom_range(0, 3))
            0: idle_pct = 0;
            1: idle_pct = 10;
            2: idle_pct = 30;
            default: idle_pct = 60;
         endcase
         if (phase == 0) begin
            n = 127;
         end else begin
            case ($urandom_range(0, 9))
               0: n = 0;
               1: n = 1;
               2: n = MAX_TRACKS;
               3: n = $urandom_range(MAX_TRACKS + 1, 127);
               4: n = $urandom_range(31, MAX_TRACKS);
               default: n = $urandom_range(2, 30);
            endcase
         end
         set_track_count(n);
         if (n >= 1 && n <= MAX_TRACKS) begin
            if (n <= 30)
               rebuild = ($urandom_range(0, 1) == 0);
            else
               rebuild = !toc_table_valid() && ($urandom_range(0, 3) == 0);
            if (rebuild) begin
               base = ($urandom_range(0, 6) == 0) ? $urandom_range(450000, 2147000000) : 0;
               build_table(n, base);
               if ($urandom_range(0, 3) == 0)
                  spoil_track($urandom_range(0, n - 1));
            end
         end
         query_burst($urandom_range(6, 20));
         phase++;
      end
   endtask

   // tail with both sides always ready
   task automatic test_quiet_finish();
      no_idling = 1'b1;
      set_track_count(20);
      build_table(20, 0);
      query_burst(40);
   endtask

   // ---------------------------------------------------------------------
   // Response side: random stall bursts, ready raised again in between
   // ---------------------------------------------------------------------
   initial begin : rsp_side
      int hold;
      hold = 0;
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_ready = 1'b0;
            hold--;
         end else begin
            rsp_ready = 1'b1;
            if (!no_idling && $urandom_range(0, 99) < idle_pct)
               hold = $urandom_range(1, 14);
         end
      end
   end

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= 30)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // each word taken on the response side against the oldest expectation
   always @(posedge clock) begin : check_answers
      toc_answer_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (answers_due.size() == 0) begin
            errors++;
            if (errors <= 30)
               $display("%0t: unexpected response, expected none, actual ok=%0b %h %h %h",
                        $time, rsp_ok, rsp_status_byte, rsp_first_bcd, rsp_second_bcd);
         end else begin
            due = answers_due.pop_front();
            answers_seen++;
            if (!due.ok)
               refusals++;
            check_field("ok", 8'(due.ok), 8'(rsp_ok));
            check_field("status_byte", due.status, rsp_status_byte);
            check_field("first_bcd", due.first, rsp_first_bcd);
            check_field("second_bcd", due.second, rsp_second_bcd);
         end
      end
   end

   // hang detector: no handshake on any port for too long
   initial begin : watchdog
      int still_cycles;
      still_cycles = 0;
      while (still_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en)
            still_cycles = 0;
         else
            still_cycles++;
      end
      $display("%0t: no progress for %0d cycles, %0d answers outstanding",
               $time, STALL_LIMIT, answers_due.size());
      $display("FAILURE");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_OTHER;
      req_entry_index = '0;
      req_entry_number = '0;
      req_entry_lba = '0;
      req_entry_sectors = '0;
      req_entry_postgap = '0;
      req_param_present = 1'b0;
      req_param_byte = '0;
      req_drive_status = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      toc_count = 0;
      errors = 0;
      words_sent = 0;
      ignored_loads = 0;
      answers_seen = 0;
      refusals = 0;
      csr_writes = 0;
      idle_pct = 30;
      no_idling = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_table();
      test_small_table();
      test_time_limit();
      test_broken_table();
      test_full_table();
      test_random_settings();
      test_quiet_finish();

      // the slowest query is a GetTD on a full table
      drain();
      repeat (150) @(posedge clock);
      $display("Sent %0d words (%0d loads to slots past the table), %0d entry count writes.",
               words_sent, ignored_loads, csr_writes);
      $display("Checked %0d answers, %0d refused; counts 0/1/99/over-range, good and broken tables.",
               answers_seen, refusals);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
